[rtl/abc_pkg.sv]
package abc_pkg;

  localparam int unsigned ValW     = 16;
  localparam int unsigned HalfW    = 15;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned CntW     = 15;
  localparam int unsigned HitIdxW  = 6;
  localparam int unsigned TblDepth = 65536;
  localparam int unsigned MapDepth = 32768;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QIdxW    = 1;

  localparam logic [ValW-1:0]    MaxValue = 16'hFFFF;
  localparam logic [ValW-1:0]    MinValue = 16'd3;
  localparam logic [ValW-1:0]    MaxValueReset = 16'hFFFF;
  localparam logic [HitIdxW-1:0] MaxHits  = 6'd63;

  typedef enum logic [1:0] {
    KIND_HIT     = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // one table row: smallest prime factor, radical, radical without that prime
  typedef struct packed {
    logic [ValW-1:0] spf;
    logic [ValW-1:0] rad;
    logic [ValW-1:0] rest;
  } tbl_entry_t;

  typedef struct packed {
    logic [ValW-1:0] addr_a;
    logic [ValW-1:0] addr_b;
  } tbl_rd_t;

  typedef struct packed {
    logic [ValW-1:0] sum_value;
    logic            err;
  } req_t;

  typedef struct packed {
    kind_e            kind;
    logic [HalfW-1:0] part_a;
    logic [ValW-1:0]  part_b;
    logic [ValW-1:0]  radical_a;
    logic [ValW-1:0]  radical_b;
    logic [ValW-1:0]  radical_c;
    logic [ProdW-1:0] radical_product;
    logic [CntW-1:0]  coprime_count;
    logic [CntW-1:0]  hit_count;
    logic             dropped;
    logic             last;
  } res_t;

endpackage

[rtl/abc_front.sv]
module abc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [abc_pkg::ValW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [abc_pkg::ValW-1:0]   sum_value_i,
  input  logic                       ready_i,
  output logic                       q_valid_o,
  output abc_pkg::req_t              q_req_o,
  input  logic                       q_pop_i
);
  import abc_pkg::*;

  logic [ValW-1:0]  max_value_q;
  req_t             ent_q [QDepth];
  logic [QIdxW-1:0] wp_q, rp_q;
  logic [QIdxW:0]   cnt_q;
  logic             push;
  req_t             req;

  assign in_stall_o = (cnt_q == (QIdxW+1)'(QDepth)) || !ready_i;
  assign push       = in_valid_i && !in_stall_o;
  assign req.sum_value = sum_value_i;
  assign req.err       = (sum_value_i < MinValue) || (sum_value_i > max_value_q);
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MaxValueReset;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_value_q <= cfg_wdata_i;
      end
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (q_pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= req;
    end
  end

endmodule

[rtl/abc_tables.sv]
module abc_tables (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abc_pkg::tbl_rd_t      rd_i,
  output abc_pkg::tbl_entry_t   data_a_o,
  output abc_pkg::tbl_entry_t   data_b_o,
  output logic                  ready_o
);
  import abc_pkg::*;

  typedef enum logic [5:0] {
    T_INIT  = 6'b000001,
    T_CHKRD = 6'b000010,
    T_CHK   = 6'b000100,
    T_MRD   = 6'b001000,
    T_MWR   = 6'b010000,
    T_DONE  = 6'b100000
  } tstate_e;

  tstate_e         state_q, state_d;
  logic [ValW-1:0] i_q, i_d;
  logic [ValW-1:0] p_q, p_d;
  logic [ValW:0]   j_q, j_d;
  logic [ValW:0]   j_next;

  tbl_entry_t      mem [TblDepth];
  tbl_entry_t      rd_a_q, rd_b_q;
  logic [ValW-1:0] addr_a, sv_addr, waddr;
  logic            we;
  tbl_entry_t      wdata;
  logic [2*ValW-1:0] rad_mul, rest_mul;

  assign ready_o  = (state_q == T_DONE);
  assign data_a_o = rd_a_q;
  assign data_b_o = rd_b_q;
  assign addr_a   = ready_o ? rd_i.addr_a : sv_addr;
  assign j_next   = j_q + {1'b0, p_q};
  assign rad_mul  = rd_a_q.rad * p_q;
  assign rest_mul = rd_a_q.rest * p_q;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    p_d     = p_q;
    j_d     = j_q;
    sv_addr = i_q;
    we      = 1'b0;
    waddr   = i_q;
    wdata   = '{spf: '0, rad: ValW'(1), rest: ValW'(1)};
    case (state_q)
      T_INIT: begin
        we = 1'b1;
        if (i_q == MaxValue) begin
          i_d     = ValW'(2);
          state_d = T_CHKRD;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      T_CHKRD: begin
        state_d = T_CHK;
      end
      T_CHK: begin
        if (rd_a_q.rad == ValW'(1)) begin
          p_d     = i_q;
          j_d     = {1'b0, i_q};
          state_d = T_MRD;
        end else if (i_q == MaxValue) begin
          state_d = T_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = T_CHKRD;
        end
      end
      T_MRD: begin
        sv_addr = j_q[ValW-1:0];
        state_d = T_MWR;
      end
      T_MWR: begin
        we    = 1'b1;
        waddr = j_q[ValW-1:0];
        if (rd_a_q.rad == ValW'(1)) begin
          wdata = '{spf: p_q, rad: p_q, rest: ValW'(1)};
        end else begin
          wdata = '{spf: rd_a_q.spf, rad: rad_mul[ValW-1:0], rest: rest_mul[ValW-1:0]};
        end
        if (j_next > {1'b0, MaxValue}) begin
          if (i_q == MaxValue) begin
            state_d = T_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = T_CHKRD;
          end
        end else begin
          j_d     = j_next;
          state_d = T_MRD;
        end
      end
      T_DONE: begin
        state_d = T_DONE;
      end
      default: begin
        state_d = T_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_INIT;
      i_q     <= '0;
      p_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      p_q     <= p_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[rd_i.addr_b];
  end

endmodule

[rtl/abc_engine.sv]
module abc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  abc_pkg::req_t        q_req_i,
  output logic                 q_pop_o,
  output abc_pkg::tbl_rd_t     tbl_rd_o,
  input  abc_pkg::tbl_entry_t  tbl_a_i,
  input  abc_pkg::tbl_entry_t  tbl_b_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output abc_pkg::res_t        res_o
);
  import abc_pkg::*;

  typedef enum logic [9:0] {
    E_IDLE = 10'b0000000001,
    E_CLR  = 10'b0000000010,
    E_FRD  = 10'b0000000100,
    E_FGET = 10'b0000001000,
    E_MARK = 10'b0000010000,
    E_SRD  = 10'b0000100000,
    E_S1   = 10'b0001000000,
    E_S2   = 10'b0010000000,
    E_S3   = 10'b0100000000,
    E_SUM  = 10'b1000000000
  } estate_e;

  estate_e            state_q, state_d;
  logic [ValW-1:0]    c_q, c_d;
  logic [HalfW-1:0]   half_q, half_d;
  logic [HalfW-1:0]   idx_q, idx_d;
  logic [ValW-1:0]    cur_q, cur_d;
  logic               first_q, first_d;
  logic [ValW-1:0]    p_q, p_d;
  logic [ValW-1:0]    rest_q, rest_d;
  logic [ValW-1:0]    radc_q, radc_d;
  logic [ValW:0]      m_q, m_d;
  logic [ValW-1:0]    a_q, a_d;
  logic [ValW-1:0]    ra_q, ra_d;
  logic [ValW-1:0]    rb_q, rb_d;
  logic [2*ValW-1:0]  p1_q, p1_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [CntW-1:0]    cop_q, cop_d;
  logic [CntW-1:0]    hits_q, hits_d;
  logic [HitIdxW-1:0] n_q, n_d;

  logic               out_valid_q;
  res_t               res_q, res_d;
  logic               out_free, load;

  logic               map_mem [MapDepth];
  logic               map_rd_q;
  logic               map_we, map_wdata;
  logic [HalfW-1:0]   map_waddr;
  logic [ValW-1:0]    b_val;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign b_val       = c_q - a_q;

  always_comb begin
    state_d   = state_q;
    c_d       = c_q;
    half_d    = half_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    first_d   = first_q;
    p_d       = p_q;
    rest_d    = rest_q;
    radc_d    = radc_q;
    m_d       = m_q;
    a_d       = a_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    p1_d      = p1_q;
    prod_d    = prod_q;
    cop_d     = cop_q;
    hits_d    = hits_q;
    n_d       = n_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    res_d     = '0;
    map_we    = 1'b0;
    map_wdata = 1'b0;
    map_waddr = idx_q;
    tbl_rd_o  = '{addr_a: cur_q, addr_b: b_val};
    case (state_q)
      E_IDLE: begin
        if (q_valid_i) begin
          if (q_req_i.err) begin
            if (out_free) begin
              q_pop_o    = 1'b1;
              load       = 1'b1;
              res_d.kind = KIND_ERROR;
              res_d.last = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            c_d     = q_req_i.sum_value;
            half_d  = HalfW'((q_req_i.sum_value - 1'b1) >> 1);
            idx_d   = '0;
            cop_d   = '0;
            hits_d  = '0;
            n_d     = '0;
            state_d = E_CLR;
          end
        end
      end
      E_CLR: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
        map_waddr = idx_q;
        if (idx_q == half_q) begin
          cur_d   = c_q;
          first_d = 1'b1;
          state_d = E_FRD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      E_FRD: begin
        state_d = E_FGET;
      end
      E_FGET: begin
        p_d    = tbl_a_i.spf;
        rest_d = tbl_a_i.rest;
        m_d    = {1'b0, tbl_a_i.spf};
        if (first_q) begin
          radc_d  = tbl_a_i.rad;
          first_d = 1'b0;
        end
        state_d = E_MARK;
      end
      E_MARK: begin
        // clear every multiple of this prime of c up to (c-1)/2 in the coprime map
        if (m_q <= {2'b0, half_q}) begin
          map_we    = 1'b1;
          map_wdata = 1'b0;
          map_waddr = m_q[HalfW-1:0];
          m_d       = m_q + {1'b0, p_q};
        end else if (rest_q == ValW'(1)) begin
          a_d     = ValW'(1);
          state_d = E_SRD;
        end else begin
          cur_d   = rest_q;
          state_d = E_FRD;
        end
      end
      E_SRD: begin
        tbl_rd_o = '{addr_a: a_q, addr_b: b_val};
        if (a_q > {1'b0, half_q}) begin
          state_d = E_SUM;
        end else begin
          state_d = E_S1;
        end
      end
      E_S1: begin
        if (map_rd_q) begin
          cop_d   = cop_q + 1'b1;
          ra_d    = tbl_a_i.rad;
          rb_d    = tbl_b_i.rad;
          p1_d    = tbl_a_i.rad * tbl_b_i.rad;
          state_d = E_S2;
        end else begin
          a_d     = a_q + 1'b1;
          state_d = E_SRD;
        end
      end
      E_S2: begin
        prod_d  = p1_q * radc_q;
        state_d = E_S3;
      end
      E_S3: begin
        if ({32'b0, c_q} <= prod_q) begin
          a_d     = a_q + 1'b1;
          state_d = E_SRD;
        end else if (n_q == MaxHits) begin
          hits_d  = hits_q + 1'b1;
          a_d     = a_q + 1'b1;
          state_d = E_SRD;
        end else if (out_free) begin
          load                  = 1'b1;
          res_d.kind            = KIND_HIT;
          res_d.part_a          = a_q[HalfW-1:0];
          res_d.part_b          = b_val;
          res_d.radical_a       = ra_q;
          res_d.radical_b       = rb_q;
          res_d.radical_c       = radc_q;
          res_d.radical_product = prod_q;
          hits_d                = hits_q + 1'b1;
          n_d                   = n_q + 1'b1;
          a_d                   = a_q + 1'b1;
          state_d               = E_SRD;
        end
      end
      E_SUM: begin
        if (out_free) begin
          load                = 1'b1;
          res_d.kind          = KIND_SUMMARY;
          res_d.coprime_count = cop_q;
          res_d.hit_count     = hits_q;
          res_d.dropped       = (hits_q > CntW'(MaxHits));
          res_d.last          = 1'b1;
          state_d             = E_IDLE;
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      cop_q       <= '0;
      hits_q      <= '0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      cop_q   <= cop_d;
      hits_q  <= hits_d;
      n_q     <= n_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    half_q <= half_d;
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    p_q    <= p_d;
    rest_q <= rest_d;
    radc_q <= radc_d;
    m_q    <= m_d;
    a_q    <= a_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    p1_q   <= p1_d;
    prod_q <= prod_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[a_q[HalfW-1:0]];
  end

endmodule

[rtl/abc_triple_radical_search_core.sv]
// abc triple search core
// after reset the block sieves its factor and radical tables: one pass
// over all 65536 entries to initialize the table memory, then a check of
// each candidate and a read and write of each multiple of each prime;
// in_stall_o stays high until this is done
// input channel: in_valid_i / in_stall_o with sum_value_i, one request per c,
// checked against 3..max_value on acceptance and held in a two-entry queue
// output channel: out_valid_o / out_stall_i, one hit result per hit (up to
// 63), then one summary with last_o set; an out-of-range c gives one error
// result with last_o set
// per request: the coprime map is set for a up to (c-1)/2, every multiple
// of each prime of c is cleared in it, then each a is checked, a coprime a
// going through the single table read pair and the two-step multiply;
// requests are served in order
// a stalled output holds its result and the scan waits at the next hit
// cfg_we_i writes max_value (65535 after reset); write only while idle
module abc_triple_radical_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sum_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [14:0] part_a_o,
  output logic [15:0] part_b_o,
  output logic [15:0] radical_a_o,
  output logic [15:0] radical_b_o,
  output logic [15:0] radical_c_o,
  output logic [47:0] radical_product_o,
  output logic [14:0] coprime_count_o,
  output logic [14:0] hit_count_o,
  output logic        dropped_o,
  output logic        last_o
);
  import abc_pkg::*;

  logic       ready;
  logic       q_valid, q_pop;
  req_t       q_req;
  tbl_rd_t    tbl_rd;
  tbl_entry_t tbl_a, tbl_b;
  res_t       res;

  abc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sum_value_i (sum_value_i),
    .ready_i     (ready),
    .q_valid_o   (q_valid),
    .q_req_o     (q_req),
    .q_pop_i     (q_pop)
  );

  abc_tables u_tables (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (tbl_rd),
    .data_a_o (tbl_a),
    .data_b_o (tbl_b),
    .ready_o  (ready)
  );

  abc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .tbl_rd_o    (tbl_rd),
    .tbl_a_i     (tbl_a),
    .tbl_b_i     (tbl_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o            = res.kind;
  assign part_a_o          = res.part_a;
  assign part_b_o          = res.part_b;
  assign radical_a_o       = res.radical_a;
  assign radical_b_o       = res.radical_b;
  assign radical_c_o       = res.radical_c;
  assign radical_product_o = res.radical_product;
  assign coprime_count_o   = res.coprime_count;
  assign hit_count_o       = res.hit_count;
  assign dropped_o         = res.dropped;
  assign last_o            = res.last;

endmodule

[rtl/abc_checker.sv]
module abc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [14:0] part_a_o,
  input logic [47:0] radical_product_o,
  input logic [14:0] hit_count_o,
  input logic        dropped_o,
  input logic        last_o
);
  import abc_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(part_a_o))
    else $error("output changed while stalled");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ERROR |-> last_o && radical_product_o == '0)
    else $error("error result malformed");

  a_hit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HIT |-> !last_o && part_a_o != '0)
    else $error("hit result malformed");

  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SUMMARY |-> (dropped_o == (hit_count_o > 15'd63)) && last_o)
    else $error("summary drop flag inconsistent");

endmodule

bind abc_triple_radical_search_core abc_checker u_abc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .kind_o            (kind_o),
  .part_a_o          (part_a_o),
  .radical_product_o (radical_product_o),
  .hit_count_o       (hit_count_o),
  .dropped_o         (dropped_o),
  .last_o            (last_o)
);
